>>> rtl/humidity_temp_frame_decoder_top_defines.svh
// Assertion macros shared by the humidity and temperature frame decoder.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Condition that must hold at every clock edge outside reset.
`define HTFD_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("htfd assertion failed");
// Consequence that must hold in the same cycle as its antecedent.
`define HTFD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("htfd assertion failed");
// Consequence that must hold in the cycle after its antecedent.
`define HTFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("htfd assertion failed");
`else
`define HTFD_ASSERT_ALWAYS(label, clk, rst, cond)
`define HTFD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define HTFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/htfd_pkg.sv
// Types, constants and arithmetic helpers of the humidity and temperature frame decoder.
package htfd_pkg;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // Byte positions inside one six-byte response.
   localparam logic [2:0] POS_T_HIGH = 3'd0;
   localparam logic [2:0] POS_T_LOW  = 3'd1;
   localparam logic [2:0] POS_T_CRC  = 3'd2;
   localparam logic [2:0] POS_H_HIGH = 3'd3;
   localparam logic [2:0] POS_H_LOW  = 3'd4;
   localparam logic [2:0] POS_H_CRC  = 3'd5;

   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [13:0] HUM_SCALE   = 14'd10000;
   localparam logic [15:0] ROUND_BIAS  = 16'd32767;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [16:0] DIV_BASE    = 17'd65535;

   localparam int unsigned TPROD_W = 31;
   localparam int unsigned HPROD_W = 30;

   // One complete response as handed from the front end to the converter.
   typedef struct packed {
      logic        temp_ok;
      logic        hum_ok;
      logic [15:0] temp_word;
      logic [15:0] hum_word;
   } htfd_frame_type;

   // CRC-8, MSB first, one byte.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Quotient by 65535 for dividends whose upper half stays well below 65535.
   // x = q0 * 65536 + lo = q0 * 65535 + (lo + q0), and the remainder term is
   // below twice the divisor, so one compare corrects the estimate.
   function automatic logic [15:0] div_by_65535(input logic [31:0] x);
      logic [15:0] q0;
      logic [16:0] rem;
      q0  = x[31:16];
      rem = {1'b0, x[15:0]} + {1'b0, q0};
      return q0 + ((rem >= DIV_BASE) ? 16'd1 : 16'd0);
   endfunction

endpackage

>>> rtl/htfd_front.sv
// Front end: framing, per-word CRC check and capture of the two raw words.
module htfd_front
   import htfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     response_byte,
   input  logic           frame_start,
   output logic           push,
   output htfd_frame_type push_frame
);

   logic [2:0] pos_ff, pos_in;
   logic [7:0] crc_ff, crc_in;
   logic       tok_ff, tok_in;
   logic [7:0] hold_ff, hold_in;
   logic [15:0] tword_ff, tword_in;
   logic [15:0] hword_ff, hword_in;
   logic [2:0] pos;
   logic [7:0] crc_next;

   always_comb begin
      pos      = frame_start ? POS_T_HIGH : pos_ff;
      crc_next = crc8_update(crc_ff, response_byte);
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      tok_in   = tok_ff;
      hold_in  = hold_ff;
      tword_in = tword_ff;
      hword_in = hword_ff;
      push     = 1'b0;
      push_frame.temp_ok   = tok_ff;
      push_frame.hum_ok    = (crc_ff == response_byte);
      push_frame.temp_word = tword_ff;
      push_frame.hum_word  = hword_ff;
      if (accept) begin
         pos_in = (pos == POS_H_CRC) ? POS_T_HIGH : pos + 3'd1;
         unique case (pos) inside
            POS_T_HIGH, POS_H_HIGH: begin
               crc_in  = crc8_update(CRC_INIT, response_byte);
               hold_in = response_byte;
            end
            POS_T_LOW: begin
               crc_in   = crc_next;
               tword_in = {hold_ff, response_byte};
            end
            POS_H_LOW: begin
               crc_in   = crc_next;
               hword_in = {hold_ff, response_byte};
            end
            POS_T_CRC: begin
               tok_in = (crc_ff == response_byte);
               crc_in = CRC_INIT;
            end
            POS_H_CRC: begin
               crc_in = CRC_INIT;
               push   = 1'b1;
            end
            default: begin
               pos_in = POS_T_HIGH;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_T_HIGH;
         crc_ff <= CRC_INIT;
         tok_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      tword_ff <= tword_in;
      hword_ff <= hword_in;
   end

endmodule

>>> rtl/htfd_queue.sv
// Short first-in first-out queue of completed responses between front and back.
module htfd_queue
   import htfd_pkg::*;
#(
   parameter int unsigned DEPTH = 2
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  htfd_frame_type push_frame,
   output logic           full,
   output logic           pop_valid,
   input  logic           pop_ready,
   output htfd_frame_type pop_frame
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   htfd_frame_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_frame = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

>>> rtl/htfd_back.sv
// Back end: scaling multiply, division by 65535 and the registered result.
module htfd_back
   import htfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  htfd_frame_type     in_frame,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_sample_valid,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi,
   output logic               rsp_temperature_check_failed,
   output logic               rsp_humidity_check_failed
);

   // Product stage.
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_ok_ff;
   logic               s1_tfail_ff;
   logic               s1_hfail_ff;
   logic [TPROD_W-1:0] s1_tprod_ff;
   logic [HPROD_W-1:0] s1_hprod_ff;

   // Result stage.
   logic               out_valid_ff, out_valid_in;
   logic               out_ok_ff;
   logic signed [14:0] out_temp_ff;
   logic [13:0]        out_hum_ff;
   logic               out_tfail_ff;
   logic               out_hfail_ff;

   logic               out_free;
   logic [15:0]        tq;
   logic [15:0]        hq;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign in_ready = !s1_valid_ff || out_free;

   assign s1_valid_in  = in_ready ? in_valid : s1_valid_ff;
   assign out_valid_in = out_free ? s1_valid_ff : out_valid_ff;

   assign tq = div_by_65535(32'(s1_tprod_ff));
   assign hq = div_by_65535(32'(s1_hprod_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         s1_ok_ff    <= in_frame.temp_ok && in_frame.hum_ok;
         s1_tfail_ff <= !in_frame.temp_ok;
         s1_hfail_ff <= !in_frame.hum_ok;
         s1_tprod_ff <= TPROD_W'(in_frame.temp_word) * TPROD_W'(TEMP_SCALE)
                        + TPROD_W'(ROUND_BIAS);
         s1_hprod_ff <= HPROD_W'(in_frame.hum_word) * HPROD_W'(HUM_SCALE)
                        + HPROD_W'(ROUND_BIAS);
      end
      if (out_free) begin
         out_ok_ff    <= s1_ok_ff;
         out_tfail_ff <= s1_tfail_ff;
         out_hfail_ff <= s1_hfail_ff;
         out_temp_ff  <= s1_ok_ff ? $signed(tq[14:0] - TEMP_OFFSET) : 15'sd0;
         out_hum_ff   <= s1_ok_ff ? hq[13:0] : 14'd0;
      end
   end

   assign rsp_valid                    = out_valid_ff;
   assign rsp_sample_valid             = out_ok_ff;
   assign rsp_temperature_centi        = out_temp_ff;
   assign rsp_humidity_centi           = out_hum_ff;
   assign rsp_temperature_check_failed = out_tfail_ff;
   assign rsp_humidity_check_failed    = out_hfail_ff;

endmodule

>>> rtl/humidity_temp_frame_decoder_top.sv
// Top level of the humidity and temperature response frame decoder.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid / req_stall  response_byte, frame_start
//   rsp       out        rsp_valid / rsp_stall  sample_valid, temperature_centi,
//                                               humidity_centi, two check flags
//
// One request byte is taken every cycle while req_stall is low; the front end updates the CRC of a byte
// in the same cycle it is accepted.
// After its sixth byte is taken, a result passes through a queue entry and the multiply
// stage register into the output register, where it is held while rsp_stall is high.
// Synchronous reset clears framing, the queue and the stage valid flags.
// req_stall rises only while the queue is full, which needs the output side
// to hold off responses for several frames.
`include "humidity_temp_frame_decoder_top_defines.svh"

module humidity_temp_frame_decoder_top
   import htfd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_response_byte,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_sample_valid,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi,
   output logic               rsp_temperature_check_failed,
   output logic               rsp_humidity_check_failed
);

   logic           req_accept;
   logic           push;
   htfd_frame_type push_frame;
   logic           queue_full;
   logic           pop_valid;
   logic           pop_ready;
   htfd_frame_type pop_frame;

   // The stall depends only on queue occupancy, never on req_valid.
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   // The front end tracks the byte position, checks each word against its CRC
   // byte and, on the last byte of a response, hands the whole frame onward.
   htfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .response_byte (req_response_byte),
      .frame_start   (req_frame_start),
      .push          (push),
      .push_frame    (push_frame)
   );

   // The queue decouples byte intake from the output side, so a stalled response
   // does not hold back the bytes of the following frames until the queue is full.
   htfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_frame  (pop_frame)
   );

   // The back end scales both raw words and divides by full scale with
   // rounding; failed frames report zero readings.
   htfd_back u_back (
      .clock                        (clock),
      .reset                        (reset),
      .in_valid                     (pop_valid),
      .in_ready                     (pop_ready),
      .in_frame                     (pop_frame),
      .rsp_valid                    (rsp_valid),
      .rsp_stall                    (rsp_stall),
      .rsp_sample_valid             (rsp_sample_valid),
      .rsp_temperature_centi        (rsp_temperature_centi),
      .rsp_humidity_centi           (rsp_humidity_centi),
      .rsp_temperature_check_failed (rsp_temperature_check_failed),
      .rsp_humidity_check_failed    (rsp_humidity_check_failed)
   );

   // A sample is valid exactly when neither word check failed.
   `HTFD_ASSERT_IMPLIES(a_valid_matches_checks, clock, reset, rsp_valid,
      rsp_sample_valid == !(rsp_temperature_check_failed || rsp_humidity_check_failed))
   // A rejected sample carries zero readings.
   `HTFD_ASSERT_IMPLIES(a_reject_zero, clock, reset, rsp_valid && !rsp_sample_valid,
      rsp_temperature_centi == 15'sd0 && rsp_humidity_centi == 14'd0)
   // Converted humidity never exceeds full scale.
   `HTFD_ASSERT_IMPLIES(a_hum_range, clock, reset, rsp_valid, rsp_humidity_centi <= 14'd10000)
   // A frame completion is never offered while the queue is full.
   `HTFD_ASSERT_ALWAYS(a_no_push_when_full, clock, reset, !(push && queue_full))

endmodule
